// ----- rtl/core/fqba_pkg.sv -----
// ----------------------------------------------------------------------------
// fqba_pkg
// Shared sizes, codes, types and tables of the fair-queuing bus arbiter.
// ----------------------------------------------------------------------------
package fqba_pkg;

    localparam int NUM_PORTS   = 8;
    localparam int NUM_SENDERS = 16;
    localparam int TIME_BITS   = 32;

    localparam int PORT_IDX_W   = $clog2(NUM_PORTS);
    localparam int SENDER_IDX_W = $clog2(NUM_SENDERS);

    // Field widths at the block boundary.
    localparam int PORT_W      = 3;
    localparam int SENDER_W    = 4;
    localparam int BANK_W      = 3;
    localparam int FIELD_T_W   = 32;
    localparam int RATE_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // A sender sum (count plus count or bank index) and the finish increment.
    localparam int SUM_W      = COUNT_W + 1;
    localparam int INC_W      = RATE_W + SUM_W;
    localparam int WRAP_DEPTH = 2 ** SUM_W;

    localparam logic [RATE_W-1:0]  CLOCK_RATE_RESET = RATE_W'(1);
    localparam logic [COUNT_W-1:0] NUM_CPUS_RESET   = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] NUM_BANKS_RESET  = COUNT_W'(4);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLOCK_RATE = 2'd0,
        CFG_NUM_CPUS   = 2'd1,
        CFG_NUM_BANKS  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        REQ_POST      = 1'b0,
        REQ_ARBITRATE = 1'b1
    } req_kind_t;

    typedef logic [TIME_BITS-1:0]    time_t;
    typedef logic [SENDER_IDX_W-1:0] sender_idx_t;
    typedef logic [PORT_IDX_W-1:0]   port_idx_t;

    typedef sender_idx_t wrap_table_t [WRAP_DEPTH];

    // Best candidate so far, as seen by the compare unit.
    typedef struct packed {
        logic  found;
        time_t start;
        time_t req_time;
    } cmp_best_t;

    typedef struct packed {
        logic  better;
        time_t start;
    } cmp_result_t;

    // Sender index folded into the sender range, built at elaboration.
    function automatic wrap_table_t build_wrap_table();
        wrap_table_t t;
        for (int i = 0; i < WRAP_DEPTH; i++) begin
            t[i] = SENDER_IDX_W'(i % NUM_SENDERS);
        end
        return t;
    endfunction

    localparam wrap_table_t SENDER_WRAP = build_wrap_table();

endpackage

// ----- rtl/core/fqba_if.sv -----
// ----------------------------------------------------------------------------
// fqba_if
// Request, response and configuration channels of the fair-queuing arbiter.
// ----------------------------------------------------------------------------
interface fqba_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [fqba_pkg::PORT_W-1:0]      port;
    logic [fqba_pkg::FIELD_T_W-1:0]   request_time;
    logic                             sender_known;
    logic [fqba_pkg::SENDER_W-1:0]    sender_id;
    logic [fqba_pkg::BANK_W-1:0]      bank_index;
    logic [fqba_pkg::FIELD_T_W-1:0]   now;

    modport source (
        output valid, req_type, port, request_time, sender_known, sender_id,
               bank_index, now,
        input  ready
    );
    modport sink (
        input  valid, req_type, port, request_time, sender_known, sender_id,
               bank_index, now,
        output ready
    );
endinterface

interface fqba_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             granted;
    logic [fqba_pkg::PORT_W-1:0]      grant_port;
    logic [fqba_pkg::SENDER_W-1:0]    grant_sender;
    logic [fqba_pkg::FIELD_T_W-1:0]   start_tag;
    logic [fqba_pkg::FIELD_T_W-1:0]   finish_tag;

    modport source (
        output valid, granted, grant_port, grant_sender, start_tag, finish_tag,
        input  ready
    );
    modport sink (
        input  valid, granted, grant_port, grant_sender, start_tag, finish_tag,
        output ready
    );
endinterface

interface fqba_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fqba_pkg::CFG_INDEX_W-1:0]  index;
    logic [fqba_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/fqba_cmp.sv -----
// ----------------------------------------------------------------------------
// fqba_cmp
// Shared tag unit: forms a candidate's start tag and ranks it against the
// best candidate found so far.
// ----------------------------------------------------------------------------
module fqba_cmp (
    input  fqba_pkg::time_t       cand_time,
    input  fqba_pkg::time_t       cand_finish,
    input  fqba_pkg::cmp_best_t   best,
    output fqba_pkg::cmp_result_t result
);

    fqba_pkg::time_t start;

    always_comb
    begin
        start = (cand_time > cand_finish) ? cand_time : cand_finish;
        result.start = start;
        // Ties on the start tag go to the earlier request; equal requests keep
        // the earlier, lower port because the scan runs upward.
        result.better = !best.found || (start < best.start) ||
                        ((start == best.start) && (cand_time < best.req_time));
    end

endmodule

// ----- rtl/core/fair_queuing_bus_arbiter.sv -----
// ----------------------------------------------------------------------------
// fair_queuing_bus_arbiter
// Start-time fair-queuing arbiter for the ports of a shared bus. A post
// request records one pending request per port; an arbitrate request grants
// the eligible port with the smallest start tag and advances its sender's
// finish tag. The block takes one request at a time. A post request goes
// from acceptance straight to the step that hands its result to the output
// register. An arbitrate request scans the ports one per cycle through a
// single tag compare unit; then one step drains the fetch stage, one computes
// the saturated finish tag and one hands the result to the output register.
// The next request is accepted once the block is back in its idle state. The
// result register frees the input side, so a new request is accepted while
// the previous result waits to be taken; that new request then stalls in its
// last step until the waiting result is taken.
// ----------------------------------------------------------------------------
module fair_queuing_bus_arbiter (
    input  logic              clk,
    input  logic              rst_n,
    fqba_req_if.sink          req,
    fqba_rsp_if.source        rsp,
    fqba_cfg_if.sink          cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [fqba_pkg::RATE_W-1:0]  clock_rate_reg;
    logic [fqba_pkg::COUNT_W-1:0] num_cpus_reg;
    logic [fqba_pkg::COUNT_W-1:0] num_banks_reg;

    logic [fqba_pkg::NUM_PORTS-1:0] pending_reg;
    fqba_pkg::time_t                pending_time_reg   [fqba_pkg::NUM_PORTS];
    fqba_pkg::sender_idx_t          pending_sender_reg [fqba_pkg::NUM_PORTS];
    fqba_pkg::time_t                sender_finish_reg  [fqba_pkg::NUM_SENDERS];

    fqba_pkg::port_idx_t   fetch_idx_reg, fetch_idx_next;
    logic                  cand_valid_reg, cand_valid_next;
    fqba_pkg::time_t       cand_time_reg, cand_time_next;
    fqba_pkg::sender_idx_t cand_sender_reg, cand_sender_next;
    fqba_pkg::port_idx_t   cand_port_reg, cand_port_next;

    logic                  best_found_reg, best_found_next;
    fqba_pkg::time_t       best_start_reg, best_start_next;
    fqba_pkg::time_t       best_time_reg, best_time_next;
    fqba_pkg::sender_idx_t best_sender_reg, best_sender_next;
    fqba_pkg::port_idx_t   best_port_reg, best_port_next;

    fqba_pkg::time_t                now_reg, now_next;
    logic [fqba_pkg::INC_W-1:0]     inc_reg, inc_next;

    logic                  res_granted_reg, res_granted_next;
    fqba_pkg::port_idx_t   res_port_reg, res_port_next;
    fqba_pkg::sender_idx_t res_sender_reg, res_sender_next;
    fqba_pkg::time_t       res_start_reg, res_start_next;
    fqba_pkg::time_t       res_finish_reg, res_finish_next;

    logic                             out_valid_reg, out_valid_next;
    logic                             out_granted_reg, out_granted_next;
    logic [fqba_pkg::PORT_W-1:0]      out_port_reg, out_port_next;
    logic [fqba_pkg::SENDER_W-1:0]    out_sender_reg, out_sender_next;
    logic [fqba_pkg::FIELD_T_W-1:0]   out_start_reg, out_start_next;
    logic [fqba_pkg::FIELD_T_W-1:0]   out_finish_reg, out_finish_next;

    logic                  req_accept;
    logic                  cfg_accept;
    logic                  post_write;
    fqba_pkg::port_idx_t   post_port;
    logic [fqba_pkg::SUM_W-1:0] post_sum;
    fqba_pkg::sender_idx_t post_sender;
    logic                  grant_write;
    logic                  comparing;
    logic [fqba_pkg::TIME_BITS:0] fin_sum;
    fqba_pkg::time_t       fin_tag;
    logic [fqba_pkg::SUM_W-1:0]   slot_count;

    fqba_pkg::cmp_best_t   cmp_best;
    fqba_pkg::cmp_result_t cmp_result;

    fqba_cmp u_cmp (
        .cand_time   (cand_time_reg),
        .cand_finish (sender_finish_reg[cand_sender_reg]),
        .best        (cmp_best),
        .result      (cmp_result)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign req_accept = req.valid && req.ready;
    assign cfg_accept = cfg.valid && cfg.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted      = out_granted_reg;
    assign rsp.grant_port   = out_port_reg;
    assign rsp.grant_sender = out_sender_reg;
    assign rsp.start_tag    = out_start_reg;
    assign rsp.finish_tag   = out_finish_reg;

    assign cmp_best.found    = best_found_reg;
    assign cmp_best.start    = best_start_reg;
    assign cmp_best.req_time = best_time_reg;

    // Post requests: an unknown sender is charged to the bank's sender slot.
    assign post_port   = fqba_pkg::PORT_IDX_W'(req.port);
    assign post_sum    = req.sender_known ? fqba_pkg::SUM_W'(req.sender_id) :
                         fqba_pkg::SUM_W'(num_cpus_reg) + fqba_pkg::SUM_W'(req.bank_index);
    assign post_sender = fqba_pkg::SENDER_WRAP[post_sum];
    assign post_write  = req_accept && (req.req_type == fqba_pkg::REQ_POST) &&
                         (int'(req.port) < fqba_pkg::NUM_PORTS);

    assign slot_count = fqba_pkg::SUM_W'(num_cpus_reg) + fqba_pkg::SUM_W'(num_banks_reg);
    assign comparing  = (state_reg == ST_SCAN) || (state_reg == ST_DRAIN);

    // One extra bit catches the carry that means the finish tag saturates.
    assign fin_sum     = {1'b0, best_start_reg} + (fqba_pkg::TIME_BITS + 1)'(inc_reg);
    assign fin_tag     = fin_sum[fqba_pkg::TIME_BITS] ? '1 :
                         fin_sum[fqba_pkg::TIME_BITS-1:0];
    assign grant_write = (state_reg == ST_FINISH) && best_found_reg;

    always_comb
    begin
        state_next       = state_reg;
        fetch_idx_next   = fetch_idx_reg;
        cand_valid_next  = cand_valid_reg;
        cand_time_next   = cand_time_reg;
        cand_sender_next = cand_sender_reg;
        cand_port_next   = cand_port_reg;
        best_found_next  = best_found_reg;
        best_start_next  = best_start_reg;
        best_time_next   = best_time_reg;
        best_sender_next = best_sender_reg;
        best_port_next   = best_port_reg;
        now_next         = now_reg;
        inc_next         = inc_reg;
        res_granted_next = res_granted_reg;
        res_port_next    = res_port_reg;
        res_sender_next  = res_sender_reg;
        res_start_next   = res_start_reg;
        res_finish_next  = res_finish_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_port_next    = out_port_reg;
        out_sender_next  = out_sender_reg;
        out_start_next   = out_start_reg;
        out_finish_next  = out_finish_reg;

        if (comparing && cand_valid_reg && cmp_result.better)
        begin
            best_found_next  = 1'b1;
            best_start_next  = cmp_result.start;
            best_time_next   = cand_time_reg;
            best_sender_next = cand_sender_reg;
            best_port_next   = cand_port_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.req_type == fqba_pkg::REQ_POST)
                    begin
                        res_granted_next = 1'b0;
                        res_port_next    = '0;
                        res_sender_next  = '0;
                        res_start_next   = '0;
                        res_finish_next  = '0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        fetch_idx_next  = '0;
                        cand_valid_next = 1'b0;
                        best_found_next = 1'b0;
                        now_next        = fqba_pkg::TIME_BITS'(req.now);
                        inc_next        = fqba_pkg::INC_W'(clock_rate_reg) *
                                          fqba_pkg::INC_W'(slot_count);
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Fetch one port per cycle; the compare unit ranks it next cycle.
                cand_valid_next  = pending_reg[fetch_idx_reg] &&
                                   (pending_time_reg[fetch_idx_reg] < now_reg);
                cand_time_next   = pending_time_reg[fetch_idx_reg];
                cand_sender_next = pending_sender_reg[fetch_idx_reg];
                cand_port_next   = fetch_idx_reg;
                fetch_idx_next   = fetch_idx_reg + 1'b1;
                if (fetch_idx_reg == fqba_pkg::PORT_IDX_W'(fqba_pkg::NUM_PORTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cand_valid_next = 1'b0;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_granted_next = best_found_reg;
                res_port_next    = best_found_reg ? best_port_reg : '0;
                res_sender_next  = best_found_reg ? best_sender_reg : '0;
                res_start_next   = best_found_reg ? best_start_reg : '0;
                res_finish_next  = best_found_reg ? fin_tag : '0;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_port_next    = fqba_pkg::PORT_W'(res_port_reg);
                    out_sender_next  = fqba_pkg::SENDER_W'(res_sender_reg);
                    out_start_next   = fqba_pkg::FIELD_T_W'(res_start_reg);
                    out_finish_next  = fqba_pkg::FIELD_T_W'(res_finish_reg);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, control flags and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cand_valid_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cand_valid_reg  <= cand_valid_next;
            best_found_reg  <= best_found_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fetch_idx_reg    <= fetch_idx_next;
        cand_time_reg    <= cand_time_next;
        cand_sender_reg  <= cand_sender_next;
        cand_port_reg    <= cand_port_next;
        best_start_reg   <= best_start_next;
        best_time_reg    <= best_time_next;
        best_sender_reg  <= best_sender_next;
        best_port_reg    <= best_port_next;
        now_reg          <= now_next;
        inc_reg          <= inc_next;
        res_granted_reg  <= res_granted_next;
        res_port_reg     <= res_port_next;
        res_sender_reg   <= res_sender_next;
        res_start_reg    <= res_start_next;
        res_finish_reg   <= res_finish_next;
        out_granted_reg  <= out_granted_next;
        out_port_reg     <= out_port_next;
        out_sender_reg   <= out_sender_next;
        out_start_reg    <= out_start_next;
        out_finish_reg   <= out_finish_next;
    end

    // Configuration registers, pending flags and sender finish tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_rate_reg <= fqba_pkg::CLOCK_RATE_RESET;
            num_cpus_reg   <= fqba_pkg::NUM_CPUS_RESET;
            num_banks_reg  <= fqba_pkg::NUM_BANKS_RESET;
            pending_reg    <= '0;
            for (int i = 0; i < fqba_pkg::NUM_SENDERS; i++)
            begin
                sender_finish_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_accept)
            begin
                case (cfg.index)
                    fqba_pkg::CFG_CLOCK_RATE: clock_rate_reg <= cfg.data;
                    fqba_pkg::CFG_NUM_CPUS:   num_cpus_reg   <= fqba_pkg::COUNT_W'(cfg.data);
                    fqba_pkg::CFG_NUM_BANKS:  num_banks_reg  <= fqba_pkg::COUNT_W'(cfg.data);
                    default:                  ;
                endcase
            end
            if (post_write)
            begin
                pending_reg[post_port] <= 1'b1;
            end
            if (grant_write)
            begin
                pending_reg[best_port_reg]         <= 1'b0;
                sender_finish_reg[best_sender_reg] <= fin_tag;
            end
        end
    end

    // The request time and sender of a port are read only while it is pending.
    always_ff @(posedge clk)
    begin
        if (post_write)
        begin
            pending_time_reg[post_port]   <= fqba_pkg::TIME_BITS'(req.request_time);
            pending_sender_reg[post_port] <= post_sender;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start the sequencer");

    a_grant_is_pending: assert property (@(posedge clk) disable iff (!rst_n)
        grant_write |-> pending_reg[best_port_reg])
        else $error("grant chosen for a port without a pending request");

    a_finish_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        grant_write |=> (res_finish_reg >= res_start_reg) && res_granted_reg)
        else $error("finish tag lies before start tag");

    a_result_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared without a finished request");
`endif

endmodule

// ----- tb/sv/fqba_grant_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqba_grant_checker
// Passive checker for the fair-queuing bus arbiter. It watches the request,
// result and register channels and keeps its own copy of the pending ports,
// the sender finish tags and the registers. For each accepted request it
// predicts the result and compares it, field by field, with the next result
// that the block hands out.
// ----------------------------------------------------------------------------
module fqba_grant_checker (
    input  logic       clk,
    input  logic       rst_n,
    fqba_req_if        req,
    fqba_rsp_if        rsp,
    fqba_cfg_if        cfg,
    output int         failures,
    output int         outstanding
);

    typedef struct packed {
        logic                  granted;
        fqba_pkg::port_idx_t   port;
        fqba_pkg::sender_idx_t sender;
        fqba_pkg::time_t       start;
        fqba_pkg::time_t       finish;
    } grant_rec_t;

    logic [fqba_pkg::RATE_W-1:0]  clock_rate;
    logic [fqba_pkg::COUNT_W-1:0] num_cpus;
    logic [fqba_pkg::COUNT_W-1:0] num_banks;

    logic                  port_pending  [fqba_pkg::NUM_PORTS];
    fqba_pkg::time_t       port_time     [fqba_pkg::NUM_PORTS];
    fqba_pkg::sender_idx_t port_sender   [fqba_pkg::NUM_PORTS];
    fqba_pkg::time_t       sender_finish [fqba_pkg::NUM_SENDERS];

    grant_rec_t expected_grants [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        failures++;
    endtask

    // A post only records the request; its result is an empty grant.
    function automatic grant_rec_t post_request(input fqba_pkg::port_idx_t p,
                                                input fqba_pkg::time_t rtime,
                                                input logic known,
                                                input fqba_pkg::sender_idx_t id,
                                                input logic [fqba_pkg::BANK_W-1:0] bank);
        logic [fqba_pkg::SUM_W-1:0] charged;
        charged = {1'b0, num_cpus} + fqba_pkg::SUM_W'(bank);
        port_pending[p] = 1'b1;
        port_time[p]    = rtime;
        port_sender[p]  = known ? id : charged[fqba_pkg::SENDER_IDX_W-1:0];
        return '0;
    endfunction

    function automatic grant_rec_t arbitrate_grant(input fqba_pkg::time_t now_tick);
        grant_rec_t                      g;
        fqba_pkg::time_t                 st;
        fqba_pkg::time_t                 best_time;
        fqba_pkg::sender_idx_t           s;
        logic [fqba_pkg::INC_W-1:0]      inc;
        logic [fqba_pkg::TIME_BITS:0]    sum;
        g = '0;
        best_time = '0;
        for (int p = 0; p < fqba_pkg::NUM_PORTS; p++) begin
            if (port_pending[p] && port_time[p] < now_tick) begin
                s  = port_sender[p];
                st = (port_time[p] > sender_finish[s]) ? port_time[p] : sender_finish[s];
                if (!g.granted || st < g.start ||
                    (st == g.start && port_time[p] < best_time))
                begin
                    g.granted = 1'b1;
                    g.start   = st;
                    g.sender  = s;
                    g.port    = fqba_pkg::port_idx_t'(p);
                    best_time = port_time[p];
                end
            end
        end
        if (g.granted)
        begin
            inc = fqba_pkg::INC_W'(clock_rate) *
                  fqba_pkg::INC_W'({1'b0, num_cpus} + {1'b0, num_banks});
            sum = {1'b0, g.start} + (fqba_pkg::TIME_BITS + 1)'(inc);
            // The finish tag saturates at the top of the time range.
            g.finish = sum[fqba_pkg::TIME_BITS] ? '1 : sum[fqba_pkg::TIME_BITS-1:0];
            sender_finish[g.sender] = g.finish;
            port_pending[g.port] = 1'b0;
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_rec_t want;
        if (!rst_n)
        begin
            clock_rate = fqba_pkg::CLOCK_RATE_RESET;
            num_cpus   = fqba_pkg::NUM_CPUS_RESET;
            num_banks  = fqba_pkg::NUM_BANKS_RESET;
            for (int p = 0; p < fqba_pkg::NUM_PORTS; p++)
                port_pending[p] = 1'b0;
            for (int s = 0; s < fqba_pkg::NUM_SENDERS; s++)
                sender_finish[s] = '0;
            expected_grants.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    fqba_pkg::CFG_CLOCK_RATE: clock_rate = cfg.data;
                    fqba_pkg::CFG_NUM_CPUS:   num_cpus   = cfg.data[fqba_pkg::COUNT_W-1:0];
                    fqba_pkg::CFG_NUM_BANKS:  num_banks  = cfg.data[fqba_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp.granted !== want.granted)
                        report_mismatch($sformatf("granted got %b want %b",
                                                  rsp.granted, want.granted));
                    if (rsp.grant_port !== want.port)
                        report_mismatch($sformatf("grant_port got %0d want %0d",
                                                  rsp.grant_port, want.port));
                    if (rsp.grant_sender !== want.sender)
                        report_mismatch($sformatf("grant_sender got %0d want %0d",
                                                  rsp.grant_sender, want.sender));
                    if (rsp.start_tag !== want.start)
                        report_mismatch($sformatf("start_tag got %h want %h",
                                                  rsp.start_tag, want.start));
                    if (rsp.finish_tag !== want.finish)
                        report_mismatch($sformatf("finish_tag got %h want %h",
                                                  rsp.finish_tag, want.finish));
                end
            end

            if (req.valid && req.ready)
            begin
                if (req.req_type == fqba_pkg::REQ_POST)
                    expected_grants.push_back(post_request(req.port, req.request_time,
                                                           req.sender_known, req.sender_id,
                                                           req.bank_index));
                else
                    expected_grants.push_back(arbitrate_grant(req.now));
            end

            outstanding <= expected_grants.size();
        end
    end

endmodule

// ----- tb/sv/fair_queuing_bus_arbiter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fair_queuing_bus_arbiter_tb
// Stimulus and verdict for the fair-queuing bus arbiter. A directed sequence
// covers empty arbitration, replaced posts, unknown senders, tag ties and
// finish tag saturation. Random phases follow under several register
// settings, with idle and stalled cycles on both sides, a long result
// hold-off and drains between phases. The checker does the comparison.
// ----------------------------------------------------------------------------
module fair_queuing_bus_arbiter_tb;

    localparam logic [fqba_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 180;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    logic            clk;
    logic            rst_n;
    int              failures;
    int              outstanding;
    int              idle_pct;
    int              hold_requests;
    int              holds_served;
    fqba_pkg::time_t tick_base;

    fqba_req_if req_ch ();
    fqba_rsp_if rsp_ch ();
    fqba_cfg_if cfg_ch ();

    fair_queuing_bus_arbiter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    fqba_grant_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is asked for.
    initial
    begin
        rsp_ch.ready = 1'b0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served++;
                rsp_ch.ready <= 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_item(input fqba_pkg::req_kind_t kind,
                             input fqba_pkg::port_idx_t p,
                             input fqba_pkg::time_t rtime,
                             input logic known,
                             input fqba_pkg::sender_idx_t id,
                             input logic [fqba_pkg::BANK_W-1:0] bank,
                             input fqba_pkg::time_t now_tick);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.port         <= p;
        req_ch.request_time <= rtime;
        req_ch.sender_known <= known;
        req_ch.sender_id    <= id;
        req_ch.bank_index   <= bank;
        req_ch.now          <= now_tick;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic post_item(input fqba_pkg::port_idx_t p, input fqba_pkg::time_t rtime,
                             input logic known, input fqba_pkg::sender_idx_t id,
                             input logic [fqba_pkg::BANK_W-1:0] bank);
        send_item(fqba_pkg::REQ_POST, p, rtime, known, id, bank, '0);
    endtask

    task automatic arbitrate_item(input fqba_pkg::time_t now_tick);
        send_item(fqba_pkg::REQ_ARBITRATE, '0, '0, 1'b0, '0, '0, now_tick);
    endtask

    // Most requests follow a moving tick so that posts become eligible;
    // the rest are fully random noise.
    task automatic random_item();
        int              pick;
        fqba_pkg::time_t rtime;
        pick = $urandom_range(99);
        if (pick < 20)
            send_item(fqba_pkg::req_kind_t'($urandom_range(1)),
                      fqba_pkg::port_idx_t'($urandom_range(7)),
                      $urandom, 1'($urandom_range(1)),
                      fqba_pkg::sender_idx_t'($urandom_range(15)),
                      3'($urandom_range(7)), $urandom);
        else if (pick < 65)
        begin
            rtime = tick_base - fqba_pkg::time_t'($urandom_range(40));
            send_item(fqba_pkg::REQ_POST, fqba_pkg::port_idx_t'($urandom_range(7)), rtime,
                      ($urandom_range(99) < 75), fqba_pkg::sender_idx_t'($urandom_range(15)),
                      3'($urandom_range(7)), $urandom);
        end
        else
        begin
            send_item(fqba_pkg::REQ_ARBITRATE, fqba_pkg::port_idx_t'($urandom_range(7)),
                      $urandom, 1'($urandom_range(1)),
                      fqba_pkg::sender_idx_t'($urandom_range(15)),
                      3'($urandom_range(7)),
                      tick_base + fqba_pkg::time_t'($urandom_range(24)));
            tick_base = tick_base + fqba_pkg::time_t'($urandom_range(30));
        end
    endtask

    task automatic write_reg(input logic [fqba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fqba_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering requests until every result has been taken.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [fqba_pkg::RATE_W-1:0]  rate;
        logic [fqba_pkg::COUNT_W-1:0] cpus;
        logic [fqba_pkg::COUNT_W-1:0] banks;
        int                           guard;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = fqba_pkg::REQ_POST;
        req_ch.port         = '0;
        req_ch.request_time = '0;
        req_ch.sender_known = 1'b0;
        req_ch.sender_id    = '0;
        req_ch.bank_index   = '0;
        req_ch.now          = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = fqba_pkg::CFG_CLOCK_RATE;
        cfg_ch.data         = '0;
        idle_pct            = 23;
        hold_requests       = 0;
        tick_base           = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sequence under the reset register values.
        arbitrate_item(32'hFFFF_FFFF);
        post_item(3'd0, 32'd0, 1'b1, 4'd0, 3'd0);
        post_item(3'd7, 32'hFFFF_FFFE, 1'b0, 4'd15, 3'd7);
        post_item(3'd3, 32'd100, 1'b1, 4'd15, 3'd0);
        post_item(3'd3, 32'd50, 1'b1, 4'd15, 3'd0);
        arbitrate_item(32'd0);
        arbitrate_item(32'd60);
        arbitrate_item(32'd60);
        arbitrate_item(32'd60);
        // Equal start and equal time: the lower port wins.
        post_item(3'd5, 32'd20, 1'b1, 4'd2, 3'd0);
        post_item(3'd2, 32'd20, 1'b1, 4'd3, 3'd0);
        // Equal start from a shared sender: the earlier request time wins.
        post_item(3'd4, 32'd3, 1'b1, 4'd0, 3'd0);
        post_item(3'd6, 32'd5, 1'b1, 4'd0, 3'd0);
        arbitrate_item(32'd30);
        arbitrate_item(32'd30);
        arbitrate_item(32'd30);
        arbitrate_item(32'd30);
        // Finish tags saturate at the top of the time range.
        arbitrate_item(32'hFFFF_FFFF);
        post_item(3'd1, 32'hFFFF_FFF0, 1'b1, 4'd11, 3'd0);
        arbitrate_item(32'hFFFF_FFF1);
        arbitrate_item(32'hFFFF_FFFF);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    rate = 8'd255; cpus = 4'd8; banks = 4'd8; tick_base = '0;
                end
                1:
                begin
                    rate = 8'd255; cpus = 4'd15; banks = 4'd15; tick_base = 32'hFFFF_E000;
                end
                2:
                begin
                    rate = 8'd0; cpus = 4'd0; banks = 4'd0; tick_base = 32'h8000_0000;
                end
                3:
                begin
                    rate = 8'd1; cpus = 4'd1; banks = 4'd0; tick_base = 32'h0000_1000;
                end
                default:
                begin
                    rate      = fqba_pkg::RATE_W'($urandom_range(1, 255));
                    cpus      = fqba_pkg::COUNT_W'($urandom_range(1, 8));
                    banks     = fqba_pkg::COUNT_W'($urandom_range(0, 8));
                    tick_base = $urandom;
                end
            endcase
            write_reg(fqba_pkg::CFG_CLOCK_RATE, rate);
            write_reg(fqba_pkg::CFG_NUM_CPUS, fqba_pkg::CFG_DATA_W'(cpus));
            write_reg(fqba_pkg::CFG_NUM_BANKS, fqba_pkg::CFG_DATA_W'(banks));
            if (ph == 1)
                write_reg(CFG_UNMAPPED, 8'hA5);
            cfg_ch.valid <= 1'b0;
            idle_pct = (ph == 2) ? 0 : 23;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // The result side stalls while requests keep coming.
                if (ph == 3 && n == 40)
                    hold_requests++;
                random_item();
            end
        end

        req_ch.valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (outstanding != 0 && guard < 5000)
        begin
            guard++;
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
